>>> sv/ipsp_pkg.sv
// Shared types and constants for the patch stream parser.
// No dependencies; used by every module of the block.
package ipsp_pkg;

   localparam int unsigned SIZE_W     = 25;
   localparam int unsigned ADDR_W     = 24;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [SIZE_W-1:0] MAIN_SIZE_RST  = 25'h100_0000;
   localparam logic [SIZE_W-1:0] EXTRA_SIZE_RST = 25'h000_0000;
   localparam logic [ADDR_W-1:0] END_MARK       = 24'h454F46;

   localparam logic CSR_MAIN_SIZE  = 1'b0;
   localparam logic CSR_EXTRA_SIZE = 1'b1;

   localparam logic ERR_HEADER = 1'b0;
   localparam logic ERR_RECORD = 1'b1;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_OFFSET  = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_LITERAL = 3'd3,
      PH_RUNLEN  = 3'd4,
      PH_FILLVAL = 3'd5,
      PH_STOPPED = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type            kind;
      logic                region;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    run_length;
      logic [BYTE_W-1:0]   data_value;
      logic                error_code;
      logic                last_of_run;
   } result_type;

   // Results produced by one parsed byte: none, one or two.
   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } push_type;

endpackage

>>> sv/ipsp_parser.sv
// Byte stage and record parser: input register, field state and result build.
// Depends on ipsp_pkg.
module ipsp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ipsp_pkg::BYTE_W-1:0]  req_patch_byte,
   input  logic                         req_end_of_file,
   input  logic [ipsp_pkg::SIZE_W-1:0]  main_size,
   input  logic [ipsp_pkg::SIZE_W-1:0]  extra_size,
   input  logic                         space,
   output ipsp_pkg::push_type           push
);

   typedef enum logic [1:0] {
      TGT_MAIN  = 2'd0,
      TGT_EXTRA = 2'd1,
      TGT_NONE  = 2'd2
   } target_type;

   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h50;
         3'd1:    c = 8'h41;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h43;
         3'd4:    c = 8'h48;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic ipsp_pkg::result_type status(input ipsp_pkg::kind_type k,
                                                   input logic err);
      ipsp_pkg::result_type r;
      r            = '0;
      r.kind       = k;
      r.error_code = err;
      return r;
   endfunction

   logic                         in_valid_ff, in_valid_in;
   logic [ipsp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                         in_eof_ff;
   logic                         accept, fire;

   ipsp_pkg::phase_type          phase_ff, phase_in;
   logic [2:0]                   cnt_ff, cnt_in;
   logic [ipsp_pkg::ADDR_W-1:0]  offset_ff, offset_in;
   logic [ipsp_pkg::LEN_W-1:0]   length_ff, length_in;
   logic [ipsp_pkg::LEN_W-1:0]   left_ff, left_in;
   logic [ipsp_pkg::ADDR_W-1:0]  wptr_ff, wptr_in;
   logic [ipsp_pkg::LEN_W-1:0]   budget_ff, budget_in;
   target_type                   target_ff, target_in;

   // Region decision for the current record
   logic [ipsp_pkg::LEN_W-1:0]   shift_len, map_len, map_budget;
   logic [ipsp_pkg::SIZE_W-1:0]  ofs_ext, diff, room;
   logic [ipsp_pkg::ADDR_W-1:0]  map_ptr;
   logic                         in_main, in_extra;
   target_type                   map_target;

   ipsp_pkg::result_type         prim;
   logic                         prim_valid;

   assign accept      = req_valid && !req_stall;
   assign fire        = in_valid_ff && space;
   assign req_stall   = in_valid_ff && !space;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_patch_byte;
         in_eof_ff  <= req_end_of_file;
      end
   end

   always_comb begin
      shift_len = {length_ff[7:0], in_byte_ff};
      map_len   = (phase_ff == ipsp_pkg::PH_LENGTH) ? shift_len : length_ff;
      ofs_ext   = {1'b0, offset_ff};
      in_main   = ofs_ext < main_size;
      diff      = ofs_ext - main_size;
      in_extra  = (extra_size != '0) && (diff < extra_size);
      room      = in_main ? (main_size - ofs_ext) : (extra_size - diff);
      if (in_main) begin
         map_target = TGT_MAIN;
         map_ptr    = offset_ff;
      end else if (in_extra) begin
         map_target = TGT_EXTRA;
         map_ptr    = diff[ipsp_pkg::ADDR_W-1:0];
      end else begin
         map_target = TGT_NONE;
         map_ptr    = '0;
      end
      if (!in_main && !in_extra) begin
         map_budget = '0;
      end else if ({9'd0, map_len} < room) begin
         map_budget = map_len;
      end else begin
         map_budget = room[ipsp_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      offset_in  = offset_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      wptr_in    = wptr_ff;
      budget_in  = budget_ff;
      target_in  = target_ff;
      prim       = '0;
      prim_valid = 1'b0;
      push       = '0;
      if (fire) begin
         case (phase_ff)
            ipsp_pkg::PH_HEADER: begin
               if (in_byte_ff != header_char(cnt_ff)) begin
                  prim       = status(ipsp_pkg::KIND_ERROR, ipsp_pkg::ERR_HEADER);
                  prim_valid = 1'b1;
                  phase_in   = ipsp_pkg::PH_STOPPED;
               end else if (cnt_ff == 3'd4) begin
                  cnt_in   = '0;
                  phase_in = ipsp_pkg::PH_OFFSET;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_OFFSET: begin
               offset_in = {offset_ff[15:0], in_byte_ff};
               if (cnt_ff == 3'd2) begin
                  cnt_in = '0;
                  if (offset_in == ipsp_pkg::END_MARK) begin
                     prim       = status(ipsp_pkg::KIND_DONE, 1'b0);
                     prim_valid = 1'b1;
                     phase_in   = ipsp_pkg::PH_STOPPED;
                  end else begin
                     length_in = '0;
                     phase_in  = ipsp_pkg::PH_LENGTH;
                  end
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_LENGTH: begin
               length_in = shift_len;
               if (cnt_ff == 3'd1) begin
                  cnt_in = '0;
                  if (shift_len == '0) begin
                     phase_in = ipsp_pkg::PH_RUNLEN;
                  end else begin
                     left_in   = shift_len;
                     target_in = map_target;
                     wptr_in   = map_ptr;
                     budget_in = map_budget;
                     phase_in  = ipsp_pkg::PH_LITERAL;
                  end
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_LITERAL: begin
               if (budget_ff != '0 && target_ff != TGT_NONE) begin
                  prim.kind       = ipsp_pkg::KIND_WRITE;
                  prim.region     = (target_ff == TGT_EXTRA);
                  prim.address    = wptr_ff;
                  prim.data_value = in_byte_ff;
                  prim_valid      = 1'b1;
                  wptr_in         = wptr_ff + 24'd1;
                  budget_in       = budget_ff - 16'd1;
               end
               if (left_ff != '0) begin
                  left_in = left_ff - 16'd1;
               end
               if (left_in == '0) begin
                  cnt_in   = '0;
                  phase_in = ipsp_pkg::PH_OFFSET;
               end
            end
            ipsp_pkg::PH_RUNLEN: begin
               length_in = shift_len;
               if (cnt_ff == 3'd1) begin
                  cnt_in   = '0;
                  phase_in = ipsp_pkg::PH_FILLVAL;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ipsp_pkg::PH_FILLVAL: begin
               target_in = map_target;
               wptr_in   = map_ptr;
               budget_in = map_budget;
               if (map_target != TGT_NONE) begin
                  prim.kind       = ipsp_pkg::KIND_FILL;
                  prim.region     = (map_target == TGT_EXTRA);
                  prim.address    = map_ptr;
                  prim.run_length = map_budget;
                  prim.data_value = in_byte_ff;
                  prim_valid      = 1'b1;
               end
               cnt_in   = '0;
               phase_in = ipsp_pkg::PH_OFFSET;
            end
            default: begin
               // stopped: drop every byte until reset
            end
         endcase

         push.res0 = prim;
         push.count = {1'b0, prim_valid};
         if (in_eof_ff && phase_in != ipsp_pkg::PH_STOPPED) begin
            if (phase_in == ipsp_pkg::PH_OFFSET && cnt_in == '0) begin
               push.res1 = status(ipsp_pkg::KIND_DONE, 1'b0);
            end else if (phase_in == ipsp_pkg::PH_HEADER) begin
               push.res1 = status(ipsp_pkg::KIND_ERROR, ipsp_pkg::ERR_HEADER);
            end else begin
               push.res1 = status(ipsp_pkg::KIND_ERROR, ipsp_pkg::ERR_RECORD);
            end
            phase_in = ipsp_pkg::PH_STOPPED;
            push.res1.last_of_run = 1'b1;
            if (prim_valid) begin
               push.count = 2'd2;
            end else begin
               push.res0  = push.res1;
               push.res1  = '0;
               push.count = 2'd1;
            end
         end else begin
            push.res0.last_of_run = prim_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ipsp_pkg::PH_HEADER;
         cnt_ff    <= '0;
         offset_ff <= '0;
         length_ff <= '0;
         left_ff   <= '0;
         wptr_ff   <= '0;
         budget_ff <= '0;
         target_ff <= TGT_MAIN;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         wptr_ff   <= wptr_in;
         budget_ff <= budget_in;
         target_ff <= target_in;
      end
   end

`ifndef SYNTHESIS
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ipsp_pkg::PH_STOPPED) |-> (push.count == 2'd0))
      else $error("results produced after the stream stopped");

   a_pair_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.res1.kind == ipsp_pkg::KIND_DONE ||
                                push.res1.kind == ipsp_pkg::KIND_ERROR))
      else $error("second result of a beat is not a stream status");

   a_none_no_budget: assert property (@(posedge clock) disable iff (reset)
      (target_ff == TGT_NONE) |-> (budget_ff == '0))
      else $error("write budget left for a skipped record");
`endif

endmodule

>>> sv/ipsp_rsp_fifo.sv
// Result buffer: takes up to two results a cycle, hands out one a cycle unless stalled.
// Depends on ipsp_pkg.
module ipsp_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  ipsp_pkg::push_type    push,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ipsp_pkg::result_type  rsp
);

   ipsp_pkg::result_type                 mem_ff [ipsp_pkg::FIFO_DEPTH];
   logic [ipsp_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ipsp_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ipsp_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic [ipsp_pkg::FIFO_PTR_W-1:0]      wr_next;
   logic                                 pop;

   // Room for a full pair of results, regardless of what leaves this cycle
   assign space     = count_ff <= ipsp_pkg::FIFO_CNT_W'(ipsp_pkg::FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp       = mem_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + ipsp_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ipsp_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + ipsp_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + ipsp_pkg::FIFO_CNT_W'(push.count)
                  - ipsp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.res1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ipsp_pkg::FIFO_CNT_W'(ipsp_pkg::FIFO_DEPTH))
      else $error("result buffer overfilled");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |->
         (count_ff <= ipsp_pkg::FIFO_CNT_W'(ipsp_pkg::FIFO_DEPTH - 2)))
      else $error("results pushed without room for a pair");
`endif

endmodule

>>> sv/ips_patch_stream_parser.sv
// Patch stream parser top level: register port, parser stage, result buffer.
// Depends on ipsp_pkg, ipsp_parser and ipsp_rsp_fifo.
// Path: an accepted byte waits in the parser's input register, its results are
// written into the result buffer, and the buffer presents them at the port in order.
// Throughput: one byte per cycle unless the buffer lacks room, set by the single parser stage and a four-entry buffer.
// Reset (synchronous): header phase, empty buffer, main_size 2^24, extra_size 0.
module ips_patch_stream_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ipsp_pkg::BYTE_W-1:0]  req_patch_byte,
   input  logic                         req_end_of_file,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic                         rsp_region,
   output logic [ipsp_pkg::ADDR_W-1:0]  rsp_address,
   output logic [ipsp_pkg::LEN_W-1:0]   rsp_run_length,
   output logic [ipsp_pkg::BYTE_W-1:0]  rsp_data_value,
   output logic                         rsp_error_code,
   output logic                         rsp_last_of_run,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [ipsp_pkg::SIZE_W-1:0]  csr_data
);

   logic [ipsp_pkg::SIZE_W-1:0]  main_size_ff;
   logic [ipsp_pkg::SIZE_W-1:0]  extra_size_ff;
   logic                         space;
   ipsp_pkg::push_type           push;
   ipsp_pkg::result_type         rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_size_ff  <= ipsp_pkg::MAIN_SIZE_RST;
         extra_size_ff <= ipsp_pkg::EXTRA_SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ipsp_pkg::CSR_MAIN_SIZE:  main_size_ff  <= csr_data;
            ipsp_pkg::CSR_EXTRA_SIZE: extra_size_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ipsp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_patch_byte  (req_patch_byte),
      .req_end_of_file (req_end_of_file),
      .main_size       (main_size_ff),
      .extra_size      (extra_size_ff),
      .space           (space),
      .push            (push)
   );

   ipsp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_region      = rsp.region;
   assign rsp_address     = rsp.address;
   assign rsp_run_length  = rsp.run_length;
   assign rsp_data_value  = rsp.data_value;
   assign rsp_error_code  = rsp.error_code;
   assign rsp_last_of_run = rsp.last_of_run;

endmodule

>>> dv/ipsp_cmd_tracker.sv
// Expected write/fill command tracker for the patch stream parser testbench.
// Depends on ipsp_pkg for result fields, widths and codes.
package ipsp_tb_pkg;
   import ipsp_pkg::*;

   localparam logic [39:0] PATCH_TEXT = "PATCH";

   typedef enum logic [2:0] {
      HDR_SCAN, OFS_FIELD, LEN_FIELD, LIT_BYTES, RUN_FIELD, FILL_BYTE, HALTED
   } parse_state_type;

   typedef enum logic [1:0] {TGT_MAIN, TGT_EXTRA, TGT_NONE} target_type;

   function automatic logic [7:0] header_char(int unsigned i);
      return PATCH_TEXT[39 - 8*i -: 8];
   endfunction

   class patch_cmd_tracker;
      logic [SIZE_W-1:0] main_size  = MAIN_SIZE_RST;
      logic [SIZE_W-1:0] extra_size = EXTRA_SIZE_RST;
      parse_state_type   state      = HDR_SCAN;
      int unsigned       fld_cnt    = 0;
      logic [ADDR_W-1:0] rec_offset = '0;
      logic [LEN_W-1:0]  rec_len    = '0;
      logic [LEN_W-1:0]  bytes_left = '0;
      logic [ADDR_W-1:0] wr_ptr     = '0;
      logic [LEN_W-1:0]  wr_budget  = '0;
      target_type        tgt        = TGT_MAIN;
      result_type        pending[$];
      int unsigned       faults     = 0;

      function void set_size(logic idx, logic [SIZE_W-1:0] value);
         if (idx == CSR_MAIN_SIZE) main_size = value;
         else extra_size = value;
      endfunction

      function void add_cmd(kind_type k, logic in_extra, logic [ADDR_W-1:0] addr,
                            logic [LEN_W-1:0] run, logic [BYTE_W-1:0] data, logic err);
         result_type r;
         r.kind        = k;
         r.region      = in_extra;
         r.address     = addr;
         r.run_length  = run;
         r.data_value  = data;
         r.error_code  = err;
         r.last_of_run = 1'b0;
         pending.push_back(r);
      endfunction

      // Decide the region for the current record and clip its length to the room left.
      function void place_record(logic [LEN_W-1:0] len);
         logic [SIZE_W-1:0] ofs;
         logic [SIZE_W-1:0] rel;
         logic [SIZE_W-1:0] room;
         ofs = {1'b0, rec_offset};
         rel = ofs - main_size;
         if (ofs < main_size) begin
            room   = main_size - ofs;
            tgt    = TGT_MAIN;
            wr_ptr = ofs[ADDR_W-1:0];
         end else if (extra_size != '0 && rel < extra_size) begin
            room   = extra_size - rel;
            tgt    = TGT_EXTRA;
            wr_ptr = rel[ADDR_W-1:0];
         end else begin
            tgt       = TGT_NONE;
            wr_ptr    = '0;
            wr_budget = '0;
            return;
         end
         wr_budget = (len < room) ? len : room[LEN_W-1:0];
      endfunction

      function void take_patch_byte(logic [BYTE_W-1:0] b, logic eof);
         int unsigned first;
         first = pending.size();
         case (state)
            HDR_SCAN: begin
               if (b !== header_char(fld_cnt)) begin
                  add_cmd(KIND_ERROR, 1'b0, '0, '0, '0, ERR_HEADER);
                  state = HALTED;
               end else begin
                  fld_cnt++;
                  if (fld_cnt >= 5) begin
                     fld_cnt = 0;
                     state   = OFS_FIELD;
                  end
               end
            end
            OFS_FIELD: begin
               rec_offset = {rec_offset[15:0], b};
               fld_cnt++;
               if (fld_cnt >= 3) begin
                  fld_cnt = 0;
                  if (rec_offset == END_MARK) begin
                     add_cmd(KIND_DONE, 1'b0, '0, '0, '0, 1'b0);
                     state = HALTED;
                  end else begin
                     rec_len = '0;
                     state   = LEN_FIELD;
                  end
               end
            end
            LEN_FIELD: begin
               rec_len = {rec_len[7:0], b};
               fld_cnt++;
               if (fld_cnt >= 2) begin
                  fld_cnt = 0;
                  if (rec_len == '0) begin
                     state = RUN_FIELD;
                  end else begin
                     bytes_left = rec_len;
                     place_record(rec_len);
                     state = LIT_BYTES;
                  end
               end
            end
            LIT_BYTES: begin
               if (wr_budget != '0 && tgt != TGT_NONE) begin
                  add_cmd(KIND_WRITE, tgt == TGT_EXTRA, wr_ptr, '0, b, 1'b0);
                  wr_ptr++;
                  wr_budget--;
               end
               // bytes beyond the clipped budget are swallowed silently
               if (bytes_left != '0) bytes_left--;
               if (bytes_left == '0) begin
                  fld_cnt = 0;
                  state   = OFS_FIELD;
               end
            end
            RUN_FIELD: begin
               rec_len = {rec_len[7:0], b};
               fld_cnt++;
               if (fld_cnt >= 2) begin
                  fld_cnt = 0;
                  state   = FILL_BYTE;
               end
            end
            FILL_BYTE: begin
               place_record(rec_len);
               if (tgt != TGT_NONE)
                  add_cmd(KIND_FILL, tgt == TGT_EXTRA, wr_ptr, wr_budget, b, 1'b0);
               fld_cnt = 0;
               state   = OFS_FIELD;
            end
            default: return;
         endcase

         if (eof && state != HALTED) begin
            if (state == OFS_FIELD && fld_cnt == 0)
               add_cmd(KIND_DONE, 1'b0, '0, '0, '0, 1'b0);
            else if (state == HDR_SCAN)
               add_cmd(KIND_ERROR, 1'b0, '0, '0, '0, ERR_HEADER);
            else
               add_cmd(KIND_ERROR, 1'b0, '0, '0, '0, ERR_RECORD);
            state = HALTED;
         end

         if (pending.size() > first) pending[pending.size() - 1].last_of_run = 1'b1;
      endfunction

      function string show(result_type r);
         return $sformatf("kind=%0d region=%0d addr=%06h run=%0d data=%02h err=%0d last=%0d",
                          r.kind, r.region, r.address, r.run_length, r.data_value,
                          r.error_code, r.last_of_run);
      endfunction

      function void flag_fault(string msg);
         faults++;
         if (faults <= 10) $display("ERROR: %s", msg);
      endfunction

      function void match_command(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            flag_fault($sformatf("result with none pending: %s", show(got)));
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind || got.region !== want.region ||
             got.address !== want.address || got.run_length !== want.run_length ||
             got.data_value !== want.data_value || got.error_code !== want.error_code ||
             got.last_of_run !== want.last_of_run)
            flag_fault($sformatf("result mismatch: expected %s, got %s",
                                 show(want), show(got)));
      endfunction
   endclass

endpackage

>>> dv/tb_ips_patch_stream_parser.sv
// Testbench for ips_patch_stream_parser: feeds one patch file, checks every command.
// Depends on ipsp_pkg and ipsp_tb_pkg (dv/ipsp_cmd_tracker.sv).
module tb_ips_patch_stream_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import ipsp_pkg::*;
   import ipsp_tb_pkg::*;

   localparam int unsigned RANDOM_BYTES  = 400;
   localparam int unsigned PHASE_BYTES   = 40;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned CYCLE_LIMIT   = 250000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_patch_byte;
   logic                req_end_of_file;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_kind;
   logic                rsp_region;
   logic [ADDR_W-1:0]   rsp_address;
   logic [LEN_W-1:0]    rsp_run_length;
   logic [BYTE_W-1:0]   rsp_data_value;
   logic                rsp_error_code;
   logic                rsp_last_of_run;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [SIZE_W-1:0]   csr_data;

   patch_cmd_tracker    tracker;
   logic [BYTE_W-1:0]   patch_bytes[$];
   int unsigned         bytes_sent = 0;
   bit                  sender_calm = 1'b0;
   bit                  sink_calm = 1'b0;
   bit                  hold_request = 1'b0;

   ips_patch_stream_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_patch_byte  (req_patch_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_region      (rsp_region),
      .rsp_address     (rsp_address),
      .rsp_run_length  (rsp_run_length),
      .rsp_data_value  (rsp_data_value),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic void push_field(logic [23:0] value, int unsigned nbytes);
      int unsigned k;
      for (k = nbytes; k > 0; k--) patch_bytes.push_back(value[8*(k-1) +: 8]);
   endfunction

   function automatic void add_header(int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) patch_bytes.push_back(header_char(i));
   endfunction

   function automatic void add_record(logic [ADDR_W-1:0] ofs, bit fill, logic [LEN_W-1:0] len,
                                      logic [BYTE_W-1:0] fill_val);
      int unsigned j;
      push_field(ofs, 3);
      if (fill) begin
         push_field(24'd0, 2);
         push_field(24'(len), 2);
         push_field(24'(fill_val), 1);
      end else begin
         push_field(24'(len), 2);
         for (j = 0; j < len; j++) push_field(24'($urandom_range(0, 255)), 1);
      end
   endfunction

   // Aim offsets at the region edges as well as anywhere in the address space.
   function automatic logic [ADDR_W-1:0] pick_offset();
      longint pos;
      longint main_sz;
      longint extra_sz;
      main_sz  = longint'(tracker.main_size);
      extra_sz = longint'(tracker.extra_size);
      case ($urandom_range(0, 9))
         0:       pos = 0;
         1:       pos = 24'hFF_FFFF;
         2:       pos = longint'($urandom_range(0, 24'hFF_FFFF));
         3, 4:    pos = main_sz + longint'($urandom_range(0, 40)) - 20;
         5:       pos = main_sz + extra_sz + longint'($urandom_range(0, 40)) - 20;
         6:       pos = main_sz + longint'($urandom_range(0, 63));
         default: pos = longint'($urandom_range(0, 63));
      endcase
      if (pos < 0) pos = 0;
      if (pos > 24'hFF_FFFF) pos = 24'hFF_FFFF;
      // keep the end marker for the terminating record only
      if (pos == longint'(END_MARK)) pos = pos - 1;
      return pos[ADDR_W-1:0];
   endfunction

   function automatic void add_random_record();
      bit               fill;
      logic [LEN_W-1:0] len;
      fill = ($urandom_range(0, 2) == 0);
      if (fill) begin
         case ($urandom_range(0, 5))
            0:       len = '0;
            1:       len = 16'hFFFF;
            2:       len = 16'($urandom_range(0, 65535));
            default: len = 16'($urandom_range(1, 40));
         endcase
      end else begin
         len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(9, 24))
                                           : 16'($urandom_range(1, 8));
      end
      add_record(pick_offset(), fill, len, 8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_main_size();
      case ($urandom_range(0, 7))
         0:       return 25'd1;
         1:       return MAIN_SIZE_RST;
         2:       return 25'd0;
         3:       return '1;
         4:       return 25'($urandom_range(0, 25'h1FF_FFFF));
         default: return 25'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_extra_size();
      case ($urandom_range(0, 7))
         0:       return 25'd0;
         1:       return 25'h100_0000;
         2:       return '1;
         3:       return 25'd1;
         default: return 25'($urandom_range(0, 64));
      endcase
   endfunction

   task automatic program_sizes(input logic [SIZE_W-1:0] main_sz,
                                input logic [SIZE_W-1:0] extra_sz);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAIN_SIZE;
      csr_data  <= main_sz;
      do @(posedge clock); while (!csr_ready);
      tracker.set_size(CSR_MAIN_SIZE, main_sz);
      csr_index <= CSR_EXTRA_SIZE;
      csr_data  <= extra_sz;
      do @(posedge clock); while (!csr_ready);
      tracker.set_size(CSR_EXTRA_SIZE, extra_sz);
      csr_valid <= 1'b0;
   endtask

   task automatic send_patch_bytes(input bit eof_last);
      int unsigned gap;
      int unsigned i;
      logic        eof;
      for (i = 0; i < patch_bytes.size(); i++) begin
         gap = draw_gap(sender_calm);
         eof = eof_last && (i == patch_bytes.size() - 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid       <= 1'b1;
         req_patch_byte  <= patch_bytes[i];
         req_end_of_file <= eof;
         do @(posedge clock); while (req_stall);
         tracker.take_patch_byte(patch_bytes[i], eof);
         bytes_sent++;
         if (bytes_sent % 32 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      end
      patch_bytes.delete();
   endtask

   // Drop valid, wait for every pending command, then let the parser go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : result_sink
      int unsigned gap;
      int unsigned beats;
      beats = 0;
      rsp_stall <= 1'b1;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            gap          = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            gap = draw_gap(sink_calm);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         beats++;
         if (beats % 24 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin : result_check
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind        = kind_type'(rsp_kind);
         got.region      = rsp_region;
         got.address     = rsp_address;
         got.run_length  = rsp_run_length;
         got.data_value  = rsp_data_value;
         got.error_code  = rsp_error_code;
         got.last_of_run = rsp_last_of_run;
         tracker.match_command(got);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned scenario;
      int unsigned phase_no;
      int unsigned cut;
      int unsigned k;
      tracker = new;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_patch_byte  <= '0;
      req_end_of_file <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_MAIN_SIZE;
      csr_data        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      program_sizes(25'd16, 25'd8);
      scenario = $urandom_range(0, 15);
      if (scenario == 0) begin
         // corrupt one header byte; everything after it is ignored
         k = $urandom_range(0, 4);
         add_header(k);
         patch_bytes.push_back(header_char(k) ^ 8'($urandom_range(1, 255)));
         send_patch_bytes(bit'($urandom_range(0, 1)));
      end else if (scenario == 1) begin
         // file ends within the header, or right after it
         add_header($urandom_range(1, 5));
         send_patch_bytes(1'b1);
      end else begin
         add_header(5);
         // literal straddling the main end: two writes, third byte dropped
         push_field(24'd14, 3);
         push_field(24'd3, 2);
         push_field(24'h00, 1);
         push_field(24'hFF, 1);
         push_field(24'h5A, 1);
         // zero-length fill in the continuation region
         add_record(24'd20, 1'b1, 16'd0, 8'hA5);
         // long fill clipped at the continuation end
         add_record(24'd22, 1'b1, 16'd300, 8'h7E);
         send_patch_bytes(1'b0);
         settle_block();

         phase_no = 0;
         while (bytes_sent < RANDOM_BYTES) begin
            if (phase_no == 2) begin
               // long literal while the sink holds off, to back up the input
               program_sizes(MAIN_SIZE_RST, 25'd0);
               hold_request = 1'b1;
               add_record(24'd0, 1'b0, 16'd24, 8'h00);
            end else begin
               program_sizes(pick_main_size(), pick_extra_size());
            end
            while (patch_bytes.size() < PHASE_BYTES) add_random_record();
            send_patch_bytes(1'b0);
            settle_block();
            phase_no++;
         end

         if ($urandom_range(0, 2) == 0) begin
            push_field(END_MARK, 3);
            send_patch_bytes(bit'($urandom_range(0, 1)));
         end else begin
            // end of file somewhere in the last record, boundary included
            add_random_record();
            cut = ($urandom_range(0, 2) == 0) ? patch_bytes.size()
                                              : $urandom_range(1, patch_bytes.size());
            while (patch_bytes.size() > cut) void'(patch_bytes.pop_back());
            send_patch_bytes(1'b1);
         end
      end

      // stray bytes after the stop must give nothing
      for (k = $urandom_range(2, 6); k > 0; k--)
         patch_bytes.push_back(8'($urandom_range(0, 255)));
      send_patch_bytes(bit'($urandom_range(0, 1)));
      settle_block();

      if (tracker.faults == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
